FILE: rtl/core/three_level_priority_ticket_queue_unit_defines.svh
// Assertion helpers for the ticket queue unit.
`ifndef THREE_LEVEL_PRIORITY_TICKET_QUEUE_UNIT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_TICKET_QUEUE_UNIT_DEFINES_SVH

// Check a property on the rising clock edge, off while reset is held.
`define TPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that an expression never holds.
`define TPQ_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: rtl/core/tpq_pkg.sv
package tpq_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_PROMOTE  = 2'd1,
    CMD_SERVE    = 2'd2,
    CMD_LOOKUP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_BADLEVEL  = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_MED  = 2'd2;
  localparam logic [1:0] LVL_LOW  = 2'd3;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] ticket_id;
    logic [11:0]        arrival_hhmm;
    logic [2:0]         new_level;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_id;
    logic [11:0]        out_hhmm;
    logic [1:0]         out_level;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [11:0] hhmm;
    logic [1:0]  level;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

  // Queue order inside one level: low is pure arrival order, the others sort on time first.
  function automatic logic precedes(entry_t a, entry_t b, logic low);
    logic r;
    if (!low && a.hhmm != b.hhmm) begin
      r = a.hhmm < b.hhmm;
    end else begin
      r = a.stamp < b.stamp;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/three_level_priority_ticket_queue_unit.sv
// Channel   Direction  Payload  Handshake
// request   in         req_t    in_valid_i / in_stall_o
// response  out        rsp_t    out_valid_o / out_stall_i
//
// Each request passes through one accept step, one memory read per slot, one step to
// drain the read pipeline and one write-back step.
// After reset a clearing pass over every slot empties the table memory;
// requests are stalled until it completes.
// A result that waits in the output register holds the write-back, and with it
// the next request, until the waiting result is taken.
`include "three_level_priority_ticket_queue_unit_defines.svh"

module three_level_priority_ticket_queue_unit import tpq_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0] CntEnd  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW:0] CntLast = (AW + 1)'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  req_t          req_q;
  logic [31:0]   ctr_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          out_valid_q;
  rsp_t          out_rsp_q;

  logic          accept, out_free, fin;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata, mem_rdata;
  scan_ctl_t     scan_ctl;

  logic          match, free, pick;
  logic [AW-1:0] match_idx, free_idx, pick_idx;
  entry_t        match_ent, pick_ent;

  logic          fin_we, fin_bump;
  logic [AW-1:0] fin_addr;
  entry_t        fin_data;
  rsp_t          rsp_d;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin      = (state_q == S_FINISH) && out_free;
  assign mem_re   = (state_q == S_SCAN) && (cnt_q != CntEnd);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q == CntEnd) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      ctr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= mem_re;
      if (fin_bump) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[AW-1:0];
    if (accept) begin
      req_q <= in_req_i;
    end
    if (fin) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign scan_ctl.clr = accept;
  assign scan_ctl.vld = rd_vld_q;

  // Write-back decision for the request once the table walk is done.
  always_comb begin
    rsp_d    = '{status: ST_OK, out_id: '0, out_hhmm: '0, out_level: LVL_NONE};
    fin_we   = 1'b0;
    fin_bump = 1'b0;
    fin_addr = match_idx;
    fin_data = match_ent;
    case (req_q.cmd)
      CMD_REGISTER: begin
        if (match) begin
          rsp_d.status = ST_DUP;
        end else if (!free) begin
          rsp_d.status = ST_FULL;
        end else begin
          fin_we   = 1'b1;
          fin_bump = 1'b1;
          fin_addr = free_idx;
          fin_data = '{valid: 1'b1, id: req_q.ticket_id, hhmm: req_q.arrival_hhmm,
                       level: LVL_LOW, stamp: ctr_q};
        end
      end
      CMD_PROMOTE: begin
        if (!match || match_ent.level != LVL_LOW) begin
          rsp_d.status = ST_NOTFOUND;
        end else if (req_q.new_level == {1'b0, LVL_HIGH} ||
                     req_q.new_level == {1'b0, LVL_MED}) begin
          fin_we         = 1'b1;
          fin_bump       = 1'b1;
          fin_data.level = req_q.new_level[1:0];
          fin_data.stamp = ctr_q;
        end else if (req_q.new_level != {1'b0, LVL_LOW}) begin
          rsp_d.status = ST_BADLEVEL;
        end
      end
      CMD_SERVE: begin
        if (!pick) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.out_id    = pick_ent.id;
          rsp_d.out_hhmm  = pick_ent.hhmm;
          rsp_d.out_level = pick_ent.level;
          fin_we          = 1'b1;
          fin_addr        = pick_idx;
          fin_data        = pick_ent;
          fin_data.valid  = 1'b0;
        end
      end
      CMD_LOOKUP: begin
        if (!match) begin
          rsp_d.status = ST_NOTFOUND;
        end else begin
          rsp_d.out_id    = match_ent.id;
          rsp_d.out_hhmm  = match_ent.hhmm;
          rsp_d.out_level = match_ent.level;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
    if (!fin) begin
      fin_we   = 1'b0;
      fin_bump = 1'b0;
    end
  end

  // Reads and writes never share a cycle: writes happen only while clearing or on write-back.
  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[AW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = fin_we;
      mem_waddr = fin_addr;
      mem_wdata = fin_data;
    end
  end

  tpq_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  tpq_scan #(
    .AW (AW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (rd_idx_q),
    .ent_i       (mem_rdata),
    .id_i        (req_q.ticket_id),
    .match_o     (match),
    .match_idx_o (match_idx),
    .match_ent_o (match_ent),
    .free_o      (free),
    .free_idx_o  (free_idx),
    .pick_o      (pick),
    .pick_idx_o  (pick_idx),
    .pick_ent_o  (pick_ent)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `TPQ_ASSERT(a_rsp_from_finish, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_FINISH), "response without write-back")
  `TPQ_ASSERT(a_ctr_hold, clk_i, rst_ni, (state_q != S_FINISH) |=> (ctr_q == $past(ctr_q)), "order counter moved outside write-back")
  `TPQ_ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, mem_we && mem_re, "table read and write in one cycle")

endmodule

FILE: rtl/core/tpq_mem.sv
module tpq_mem import tpq_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tpq_scan.sv
module tpq_scan import tpq_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scan_ctl_t     ctl_i,
  input  logic [AW-1:0] idx_i,
  input  entry_t        ent_i,
  input  logic [31:0]   id_i,
  output logic          match_o,
  output logic [AW-1:0] match_idx_o,
  output entry_t        match_ent_o,
  output logic          free_o,
  output logic [AW-1:0] free_idx_o,
  output logic          pick_o,
  output logic [AW-1:0] pick_idx_o,
  output entry_t        pick_ent_o
);

  logic          match_q;
  logic [AW-1:0] match_idx_q;
  entry_t        match_ent_q;
  logic          free_q;
  logic [AW-1:0] free_idx_q;
  // One front candidate per level: lane 0 high, 1 medium, 2 low.
  logic          best_q     [3];
  logic [AW-1:0] best_idx_q [3];
  entry_t        best_ent_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        best_q[l] <= 1'b0;
      end
    end else if (ctl_i.clr) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        best_q[l] <= 1'b0;
      end
    end else if (ctl_i.vld) begin
      if (ent_i.valid && ent_i.id == id_i) begin
        match_q <= 1'b1;
      end
      if (!ent_i.valid && !free_q) begin
        free_q <= 1'b1;
      end
      for (int l = 0; l < 3; l++) begin
        if (ent_i.valid && ent_i.level == 2'(l + 1) &&
            (!best_q[l] || precedes(ent_i, best_ent_q[l], l == 2))) begin
          best_q[l] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      if (ent_i.valid && ent_i.id == id_i) begin
        match_idx_q <= idx_i;
        match_ent_q <= ent_i;
      end
      if (!ent_i.valid && !free_q) begin
        free_idx_q <= idx_i;
      end
      for (int l = 0; l < 3; l++) begin
        if (ent_i.valid && ent_i.level == 2'(l + 1) &&
            (!best_q[l] || precedes(ent_i, best_ent_q[l], l == 2))) begin
          best_idx_q[l] <= idx_i;
          best_ent_q[l] <= ent_i;
        end
      end
    end
  end

  assign match_o     = match_q;
  assign match_idx_o = match_idx_q;
  assign match_ent_o = match_ent_q;
  assign free_o      = free_q;
  assign free_idx_o  = free_idx_q;

  always_comb begin
    pick_o     = 1'b0;
    pick_idx_o = best_idx_q[2];
    pick_ent_o = best_ent_q[2];
    if (best_q[0]) begin
      pick_o     = 1'b1;
      pick_idx_o = best_idx_q[0];
      pick_ent_o = best_ent_q[0];
    end else if (best_q[1]) begin
      pick_o     = 1'b1;
      pick_idx_o = best_idx_q[1];
      pick_ent_o = best_ent_q[1];
    end else if (best_q[2]) begin
      pick_o     = 1'b1;
    end
  end

endmodule
